// File: rtl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// shared types and constants of the screen diff refresh core: transaction
// payloads, token kinds, register indexes and shadow sizing
// ----------------------------------------------------------------------------
package sdr_pkg;

   localparam int MAX_COLS     = 220;
   localparam int MAX_ROWS     = 70;
   localparam int SHADOW_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int IDX_W        = $clog2(SHADOW_DEPTH);
   localparam int FILL_W       = $clog2(SHADOW_DEPTH + 1);

   localparam logic [7:0] MIN_COLS = 8'd40;
   localparam logic [6:0] MIN_ROWS = 7'd12;
   localparam logic [7:0] TOP_COLS = 8'((MAX_COLS > 255) ? 255 : MAX_COLS);
   localparam logic [6:0] TOP_ROWS = 7'((MAX_ROWS > 127) ? 127 : MAX_ROWS);

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [6:0] HEIGHT_RESET = 7'd24;
   localparam logic [7:0] TEXT_RESET   = 8'h00;
   localparam logic [7:0] ATTR_RESET   = 8'hff;
   localparam logic [7:0] ATTR_TOP     = 8'd5;

   typedef enum logic [1:0] {
      TOKEN_CLEAR = 2'd0,
      TOKEN_MOVE  = 2'd1,
      TOKEN_ATTR  = 2'd2,
      TOKEN_PUT   = 2'd3
   } token_kind_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic       frame_start;
      logic       force_repaint;
   } req_payload_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [6:0]     row;
      logic [7:0]     col;
      logic [2:0]     attr_code;
      logic [7:0]     character;
      logic           last;
   } rsp_payload_type;

endpackage

// File: rtl/screen_diff_refresh_core.sv
// ----------------------------------------------------------------------------
// screen_diff_refresh_core
// compares a raster stream of character cells with a shadow screen and emits
// clear, move cursor, set attribute and put character tokens for changes
// ----------------------------------------------------------------------------
// One input transaction at a time: each accepted cell passes through accept,
// frame handling, address, shadow read, compare/write-back and hand-off of the
// first token, then hands off each further token (up to four tokens per cell);
// a stalled result side holds a token until it is taken. A cell outside a shown
// frame skips the read and compare. The pace is set by the read-modify-write of
// the single shadow memory (character and attribute in one 16-bit word).
// A screen clear needs no memory pass: a fill count marks the entries written
// since the last clear, entries beyond it read as blank text with attribute
// 0xff. Registers are at byte address 0 (frame width) and 4 (frame height);
// new sizes take effect at the next frame start.
// ----------------------------------------------------------------------------
module screen_diff_refresh_core import sdr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FRAME = 6'b000010,
      S_ADDR  = 6'b000100,
      S_READ  = 6'b001000,
      S_CMP   = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [7:0]      frame_width_ff, frame_width_in;
   logic [6:0]      frame_height_ff, frame_height_in;
   logic [7:0]      shown_width_ff, shown_width_in;
   logic [6:0]      shown_height_ff, shown_height_in;
   logic [7:0]      cursor_col_ff, cursor_col_in;
   logic            cursor_col_known_ff, cursor_col_known_in;
   logic [6:0]      cursor_row_ff, cursor_row_in;
   logic            cursor_row_known_ff, cursor_row_known_in;
   logic [2:0]      current_attr_ff, current_attr_in;
   logic            current_attr_known_ff, current_attr_known_in;
   logic [6:0]      cell_row_ff, cell_row_in;
   logic [7:0]      cell_col_ff, cell_col_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [3:0]      mask_ff, mask_in;
   logic            rsp_valid_ff, rsp_valid_in;

   req_payload_type item_ff, item_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [6:0]      tok_row_ff, tok_row_in;
   logic [7:0]      tok_col_ff, tok_col_in;
   logic [2:0]      tok_attr_ff, tok_attr_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [15:0]     shadow_mem [SHADOW_DEPTH];
   logic [15:0]     rd_data_ff;
   logic            mem_we;
   logic [15:0]     mem_wdata;

   logic            csr_write;
   logic [7:0]      clamp_w;
   logic [6:0]      clamp_h;
   logic [14:0]     row_base;
   logic            fresh;
   logic [7:0]      old_text;
   logic [7:0]      old_attr;
   logic            changed;
   logic [2:0]      new_attr;
   logic [3:0]      pick;
   logic [3:0]      mask_rest;
   logic            slot_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_reg_type'(csr_paddr[2]))
         REG_FRAME_WIDTH:  csr_prdata = {24'd0, frame_width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {25'd0, frame_height_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;

   // saturated frame size
   always_comb begin
      if (frame_width_ff < MIN_COLS) begin
         clamp_w = MIN_COLS;
      end else if (frame_width_ff > TOP_COLS) begin
         clamp_w = TOP_COLS;
      end else begin
         clamp_w = frame_width_ff;
      end
      if (frame_height_ff < MIN_ROWS) begin
         clamp_h = MIN_ROWS;
      end else if (frame_height_ff > TOP_ROWS) begin
         clamp_h = TOP_ROWS;
      end else begin
         clamp_h = frame_height_ff;
      end
   end

   assign row_base  = 15'(cell_row_ff) * 15'(shown_width_ff);
   assign fresh     = (FILL_W'(idx_ff) >= fill_ff);
   assign old_text  = fresh ? TEXT_RESET : rd_data_ff[15:8];
   assign old_attr  = fresh ? ATTR_RESET : rd_data_ff[7:0];
   assign changed   = (old_text != item_ff.cell_char) || (old_attr != item_ff.cell_attr);
   assign new_attr  = (item_ff.cell_attr > ATTR_TOP) ? 3'd0 : item_ff.cell_attr[2:0];
   assign pick      = mask_ff & (~mask_ff + 4'd1);
   assign mask_rest = mask_ff & ~pick;
   assign mem_we    = (state_ff == S_CMP);
   assign mem_wdata = changed ? {item_ff.cell_char, item_ff.cell_attr} : {old_text, old_attr};

   always_comb begin
      state_in              = state_ff;
      frame_width_in        = frame_width_ff;
      frame_height_in       = frame_height_ff;
      shown_width_in        = shown_width_ff;
      shown_height_in       = shown_height_ff;
      cursor_col_in         = cursor_col_ff;
      cursor_col_known_in   = cursor_col_known_ff;
      cursor_row_in         = cursor_row_ff;
      cursor_row_known_in   = cursor_row_known_ff;
      current_attr_in       = current_attr_ff;
      current_attr_known_in = current_attr_known_ff;
      cell_row_in           = cell_row_ff;
      cell_col_in           = cell_col_ff;
      fill_in               = fill_ff;
      mask_in               = mask_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      item_in               = item_ff;
      idx_in                = idx_ff;
      tok_row_in            = tok_row_ff;
      tok_col_in            = tok_col_ff;
      tok_attr_in           = tok_attr_ff;
      rsp_payload_in        = rsp_payload_ff;

      if (csr_write) begin
         unique case (csr_reg_type'(csr_paddr[2]))
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[7:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[6:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               mask_in  = 4'd0;
               state_in = S_FRAME;
            end
         end
         S_FRAME: begin
            if (item_ff.frame_start) begin
               if (item_ff.force_repaint || clamp_w != shown_width_ff ||
                   clamp_h != shown_height_ff) begin
                  shown_width_in        = clamp_w;
                  shown_height_in       = clamp_h;
                  cursor_col_known_in   = 1'b0;
                  cursor_row_known_in   = 1'b0;
                  current_attr_known_in = 1'b0;
                  fill_in               = '0;
                  mask_in               = 4'b0001;
               end
               cell_row_in = 7'd0;
               cell_col_in = 8'd0;
            end
            state_in = S_ADDR;
         end
         S_ADDR: begin
            if (shown_width_ff != 8'd0 && shown_height_ff != 7'd0 &&
                cell_row_ff < shown_height_ff) begin
               idx_in   = IDX_W'(row_base + 15'(cell_col_ff));
               state_in = S_READ;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (FILL_W'(idx_ff) == fill_ff) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            tok_row_in  = cell_row_ff;
            tok_col_in  = cell_col_ff;
            tok_attr_in = new_attr;
            if (changed) begin
               if (!(cursor_col_known_ff && cursor_row_known_ff &&
                     cursor_col_ff == cell_col_ff && cursor_row_ff == cell_row_ff)) begin
                  mask_in[1]          = 1'b1;
                  cursor_row_in       = cell_row_ff;
                  cursor_row_known_in = 1'b1;
               end
               if (!current_attr_known_ff || current_attr_ff != new_attr) begin
                  mask_in[2]            = 1'b1;
                  current_attr_in       = new_attr;
                  current_attr_known_in = 1'b1;
               end
               mask_in[3] = 1'b1;
               if (cell_col_ff + 8'd1 >= shown_width_ff) begin
                  cursor_col_known_in = 1'b0;
                  cursor_col_in       = 8'd0;
               end else begin
                  cursor_col_known_in = 1'b1;
                  cursor_col_in       = cell_col_ff + 8'd1;
               end
            end
            if (cell_col_ff + 8'd1 >= shown_width_ff) begin
               cell_col_in = 8'd0;
               cell_row_in = cell_row_ff + 7'd1;
            end else begin
               cell_col_in = cell_col_ff + 8'd1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (mask_ff == 4'd0) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rsp_payload_in      = '0;
               rsp_payload_in.last = (mask_rest == 4'd0);
               if (pick[1]) begin
                  rsp_payload_in.token_kind = TOKEN_MOVE;
                  rsp_payload_in.row        = tok_row_ff;
                  rsp_payload_in.col        = tok_col_ff;
               end else if (pick[2]) begin
                  rsp_payload_in.token_kind = TOKEN_ATTR;
                  rsp_payload_in.attr_code  = tok_attr_ff;
               end else if (pick[3]) begin
                  rsp_payload_in.token_kind = TOKEN_PUT;
                  rsp_payload_in.character  = item_ff.cell_char;
               end else begin
                  rsp_payload_in.token_kind = TOKEN_CLEAR;
               end
               rsp_valid_in = 1'b1;
               mask_in      = mask_rest;
               if (mask_rest == 4'd0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= S_IDLE;
         frame_width_ff        <= WIDTH_RESET;
         frame_height_ff       <= HEIGHT_RESET;
         shown_width_ff        <= 8'd0;
         shown_height_ff       <= 7'd0;
         cursor_col_ff         <= 8'd0;
         cursor_col_known_ff   <= 1'b0;
         cursor_row_ff         <= 7'd0;
         cursor_row_known_ff   <= 1'b0;
         current_attr_ff       <= 3'd0;
         current_attr_known_ff <= 1'b0;
         cell_row_ff           <= 7'd0;
         cell_col_ff           <= 8'd0;
         fill_ff               <= '0;
         mask_ff               <= 4'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         frame_width_ff        <= frame_width_in;
         frame_height_ff       <= frame_height_in;
         shown_width_ff        <= shown_width_in;
         shown_height_ff       <= shown_height_in;
         cursor_col_ff         <= cursor_col_in;
         cursor_col_known_ff   <= cursor_col_known_in;
         cursor_row_ff         <= cursor_row_in;
         cursor_row_known_ff   <= cursor_row_known_in;
         current_attr_ff       <= current_attr_in;
         current_attr_known_ff <= current_attr_known_in;
         cell_row_ff           <= cell_row_in;
         cell_col_ff           <= cell_col_in;
         fill_ff               <= fill_in;
         mask_ff               <= mask_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      idx_ff         <= idx_in;
      tok_row_ff     <= tok_row_in;
      tok_col_ff     <= tok_col_in;
      tok_attr_ff    <= tok_attr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // shadow screen, character in the upper byte
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[idx_ff] <= mem_wdata;
      end
      rd_data_ff <= shadow_mem[idx_ff];
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(SHADOW_DEPTH))
      else $error("shadow fill count beyond depth");

   a_idx_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (FILL_W'(idx_ff) <= fill_ff))
      else $error("shadow access skips unfilled entries");

   a_cursor_in_frame: assert property (@(posedge clock) disable iff (reset)
      cursor_col_known_ff |-> (cursor_col_ff < shown_width_ff))
      else $error("tracked cursor column outside frame");

   a_token_after_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |=> (mask_ff != 4'd0 || !$past(changed)))
      else $error("changed cell produced no token");
`endif

endmodule

// File: dv/tb_screen_diff_refresh_core.sv
// ----------------------------------------------------------------------------
// tb_screen_diff_refresh_core
// self-checking bench for the screen diff refresh core: cell transactions go
// in through a stalling sender, every token that comes out is compared field
// by field with the next token of an in-bench shadow screen predictor, and
// frame sizes are changed through the register port between phases
// ----------------------------------------------------------------------------
module tb_screen_diff_refresh_core;
   import sdr_pkg::*;

   localparam int RANDOM_ITEMS  = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [2:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   // predictor state
   logic [7:0]      frame_cols_reg = WIDTH_RESET;
   logic [6:0]      frame_rows_reg = HEIGHT_RESET;
   int              shown_cols = 0;
   int              shown_rows = 0;
   int              cur_col = 0;
   int              cur_row = 0;
   int              cur_attr = 0;
   bit              cur_col_valid = 1'b0;
   bit              cur_row_valid = 1'b0;
   bit              cur_attr_valid = 1'b0;
   int              scan_row = 0;
   int              scan_col = 0;
   logic [15:0]     shadow[int];

   rsp_payload_type pending_tokens[$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              idle_enable = 1'b1;
   bit              hold_toggle = 1'b0;
   bit              hold_seen = 1'b0;
   int              hold_left = 0;
   int              stall_left = 0;

   screen_diff_refresh_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int sender_gap();
      if (!idle_enable || $urandom_range(0, 99) < 50) return 0;
      return idle_length();
   endfunction

   // receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 99) < 30) begin
         stall_left = idle_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : token_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("token_kind: expected none, actual %0d", rsp_payload.token_kind);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            check_field("token_kind", want.token_kind, rsp_payload.token_kind);
            check_field("row", want.row, rsp_payload.row);
            check_field("col", want.col, rsp_payload.col);
            check_field("attr_code", want.attr_code, rsp_payload.attr_code);
            check_field("character", want.character, rsp_payload.character);
            check_field("last", want.last, rsp_payload.last);
         end
      end
   end

   function automatic rsp_payload_type token_of(input token_kind_type kind, input int row,
                                                 input int col, input int attr, input int ch);
      rsp_payload_type t;
      t.token_kind = kind;
      t.row        = 7'(row);
      t.col        = 8'(col);
      t.attr_code  = 3'(attr);
      t.character  = 8'(ch);
      t.last       = 1'b0;
      return t;
   endfunction

   function automatic req_payload_type cell_of(input int ch, input int attr, input bit start,
                                               input bit repaint);
      req_payload_type c;
      c.cell_char     = 8'(ch);
      c.cell_attr     = 8'(attr);
      c.frame_start   = start;
      c.force_repaint = repaint;
      return c;
   endfunction

   function automatic int random_attr();
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
      return $urandom_range(0, 255);
   endfunction

   // shadow screen diff for one accepted cell
   function automatic void compute_tokens(input req_payload_type txn);
      rsp_payload_type burst[$];
      int              w;
      int              h;
      int              idx;
      int              attr;
      logic [15:0]     stored;
      if (txn.frame_start) begin
         w = frame_cols_reg;
         h = frame_rows_reg;
         if (w < MIN_COLS) w = MIN_COLS;
         if (w > TOP_COLS) w = TOP_COLS;
         if (h < MIN_ROWS) h = MIN_ROWS;
         if (h > TOP_ROWS) h = TOP_ROWS;
         if (txn.force_repaint || w != shown_cols || h != shown_rows) begin
            shown_cols = w;
            shown_rows = h;
            shadow.delete();
            cur_col_valid  = 1'b0;
            cur_row_valid  = 1'b0;
            cur_attr_valid = 1'b0;
            burst.push_back(token_of(TOKEN_CLEAR, 0, 0, 0, 0));
         end
         scan_row = 0;
         scan_col = 0;
      end
      if (shown_cols != 0 && shown_rows != 0 && scan_row < shown_rows) begin
         idx = scan_row * shown_cols + scan_col;
         stored = shadow.exists(idx) ? shadow[idx] : {TEXT_RESET, ATTR_RESET};
         if (stored != {txn.cell_char, txn.cell_attr}) begin
            shadow[idx] = {txn.cell_char, txn.cell_attr};
            if (!(cur_col_valid && cur_row_valid && cur_col == scan_col
                  && cur_row == scan_row)) begin
               burst.push_back(token_of(TOKEN_MOVE, scan_row, scan_col, 0, 0));
               cur_col = scan_col;
               cur_row = scan_row;
               cur_col_valid = 1'b1;
               cur_row_valid = 1'b1;
            end
            attr = (txn.cell_attr > ATTR_TOP) ? 0 : txn.cell_attr;
            if (!cur_attr_valid || cur_attr != attr) begin
               burst.push_back(token_of(TOKEN_ATTR, 0, 0, attr, 0));
               cur_attr = attr;
               cur_attr_valid = 1'b1;
            end
            burst.push_back(token_of(TOKEN_PUT, 0, 0, 0, txn.cell_char));
            if (scan_col + 1 >= shown_cols) begin
               cur_col_valid = 1'b0;
               cur_col = 0;
            end else begin
               cur_col = (cur_col + 1) & 8'hff;
            end
         end
         scan_col++;
         if (scan_col >= shown_cols) begin
            scan_col = 0;
            scan_row++;
         end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_tokens.push_back(burst[i]);
   endfunction

   task automatic send_cell(input req_payload_type txn);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= txn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      compute_tokens(txn);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every outstanding token arrive
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input int cols, input int rows);
      logic [31:0] noise;
      noise = $urandom;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_FRAME_WIDTH, 2'b00};
      csr_pwdata  <= {noise[31:8], 8'(cols)};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      frame_cols_reg = 8'(cols);
      noise = $urandom;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_FRAME_HEIGHT, 2'b00};
      csr_pwdata  <= {noise[31:8], 8'(rows)};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      frame_rows_reg = 7'(rows);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_directed_cells();
      // nothing shown yet, so stray cells and a lone repaint are dropped
      send_cell(cell_of(8'h41, 1, 1'b0, 1'b1));
      send_cell(cell_of(8'h42, 2, 1'b0, 1'b0));
      // first frame at reset size, blank cell gives the clear alone
      send_cell(cell_of(8'h00, 8'hff, 1'b1, 1'b0));
      send_cell(cell_of(8'hff, 0, 1'b0, 1'b0));
      send_cell(cell_of(8'h00, 5, 1'b0, 1'b0));
      send_cell(cell_of(8'h80, 5, 1'b0, 1'b0));
      send_cell(cell_of(8'h00, 8'hff, 1'b0, 1'b0));
      send_cell(cell_of(8'h7f, 6, 1'b0, 1'b0));
      send_cell(cell_of(8'h20, 0, 1'b0, 1'b0));
      send_cell(cell_of(8'h21, 8'hff, 1'b0, 1'b1));
      send_cell(cell_of(8'h55, 8'haa, 1'b0, 1'b0));
      // same size again: no clear, but changed cells still give tokens
      send_cell(cell_of(8'hff, 0, 1'b1, 1'b0));
      send_cell(cell_of(8'h00, 5, 1'b0, 1'b0));
      send_cell(cell_of(8'h81, 5, 1'b0, 1'b0));
      // repaint request with a frame start
      send_cell(cell_of(8'hff, 0, 1'b1, 1'b1));
      send_cell(cell_of(8'h5a, 3, 1'b0, 1'b0));
      send_cell(cell_of(8'ha5, 4, 1'b0, 1'b0));
   endtask

   task automatic test_size_limits();
      int pos;
      // below the minimum saturates to 40 x 12; cross the right edge
      settle_block();
      write_frame_size(0, 0);
      for (pos = 0; pos < 42; pos++)
         send_cell(cell_of($urandom_range(1, 255), random_attr(), pos == 0, 1'b0));
      // above the maximum saturates to 220 x 70
      settle_block();
      write_frame_size(255, 127);
      for (pos = 0; pos < 6; pos++)
         send_cell(cell_of($urandom_range(1, 255), random_attr(), pos == 0, 1'b0));
      // just above the top gives the same size, so no clear
      settle_block();
      write_frame_size(221, 71);
      for (pos = 0; pos < 5; pos++)
         send_cell(cell_of($urandom_range(0, 255), random_attr(), pos == 0, 1'b0));
      settle_block();
      write_frame_size(39, 11);
      for (pos = 0; pos < 4; pos++)
         send_cell(cell_of($urandom_range(0, 255), random_attr(), pos == 0, 1'b0));
      // a write mid-frame only counts from the next frame start
      settle_block();
      write_frame_size(60, 20);
      for (pos = 0; pos < 3; pos++)
         send_cell(cell_of($urandom_range(0, 255), random_attr(), 1'b0, 1'b0));
      send_cell(cell_of($urandom_range(0, 255), random_attr(), 1'b1, 1'b0));
      send_cell(cell_of($urandom_range(0, 255), random_attr(), 1'b0, 1'b0));
   endtask

   task automatic test_frame_repeat();
      logic [15:0] scene[int];
      int          pos;
      settle_block();
      write_frame_size(40, 12);
      // first rows of a frame, then a mostly unchanged repeat
      for (pos = 0; pos < 45; pos++) begin
         scene[pos] = {8'($urandom_range(0, 255)), 8'(random_attr())};
         send_cell(cell_of(scene[pos][15:8], scene[pos][7:0], pos == 0, pos == 0));
      end
      for (pos = 0; pos < 20; pos++) begin
         if ($urandom_range(0, 4) == 0)
            scene[pos] = {8'($urandom_range(0, 255)), 8'(random_attr())};
         send_cell(cell_of(scene[pos][15:8], scene[pos][7:0], pos == 0, 1'b0));
      end
   endtask

   task automatic test_backpressure();
      int pos;
      settle_block();
      idle_enable <= 1'b0;
      hold_toggle <= !hold_toggle;
      for (pos = 0; pos < 30; pos++)
         send_cell(cell_of($urandom_range(1, 255), random_attr(), pos == 0, pos == 0));
      settle_block();
      idle_enable <= 1'b1;
      for (pos = 0; pos < 5; pos++)
         send_cell(cell_of($urandom_range(0, 255), random_attr(), 1'b0, 1'b0));
   endtask

   task automatic test_random_frames();
      logic [15:0] scene[int];
      int          sent;
      int          frame_len;
      int          pos;
      int          cols;
      int          rows;
      bit          start;
      bit          repaint;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  cols = 0;
                  rows = 0;
               end
               1: begin
                  cols = 255;
                  rows = 255;
               end
               2: begin
                  cols = 40;
                  rows = 12;
               end
               default: begin
                  cols = $urandom_range(0, 255);
                  rows = $urandom_range(0, 255);
               end
            endcase
            settle_block();
            write_frame_size(cols, rows);
         end
         idle_enable <= ($urandom_range(0, 3) != 0);
         frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                                  : $urandom_range(4, 20);
         for (pos = 0; pos < frame_len; pos++) begin
            if (!scene.exists(pos) || $urandom_range(0, 99) < 30)
               scene[pos] = {8'($urandom_range(0, 255)), 8'(random_attr())};
            start   = (pos == 0);
            repaint = (pos == 0) && ($urandom_range(0, 7) == 0);
            // occasional stray control bits
            if ($urandom_range(0, 19) == 0) begin
               start   = $urandom_range(0, 1);
               repaint = $urandom_range(0, 1);
            end
            send_cell(cell_of(scene[pos][15:8], scene[pos][7:0], start, repaint));
            sent++;
         end
      end
      idle_enable <= 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cells();
      test_size_limits();
      test_frame_repeat();
      test_backpressure();
      test_random_frames();
      settle_block();
      if (error_count == 0 && pending_tokens.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/sdr_pkg.sv
rtl/screen_diff_refresh_core.sv
dv/tb_screen_diff_refresh_core.sv
